// ===== sv/srm_pkg.sv =====
package srm_pkg;

  localparam int SINE_INDEX_BITS = 10;
  localparam int SAMPLE_BITS     = 24;

  localparam int QUARTER_BITS = SINE_INDEX_BITS - 2;
  localparam int QUARTER      = 1 << QUARTER_BITS;
  localparam int SINE_MAG_W   = 15;
  localparam int SINE_W       = SINE_MAG_W + 1;

  // datapath widths
  localparam int GAIN_W  = 17;
  localparam int LFO_W   = 18;
  localparam int MOD_W   = SAMPLE_BITS + 2;
  localparam int WET_W   = SAMPLE_BITS + 4;
  localparam int MUL_A_W = WET_W;
  localparam int MUL_B_W = GAIN_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = PROD_W + 2;

  // configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TONE_STEP    = 3'd0,
    REG_PHASE_OFFSET = 3'd1,
    REG_MOD_DEPTH    = 3'd2,
    REG_WET_MIX      = 3'd3,
    REG_STEREO_WIDTH = 3'd4
  } cfg_reg_t;

  localparam logic [31:0]       TONE_STEP_RST    = 32'd42852281;
  localparam logic [15:0]       PHASE_OFFSET_RST = 16'd0;
  localparam logic [GAIN_W-1:0] MOD_DEPTH_RST    = 17'd32768;
  localparam logic [GAIN_W-1:0] WET_MIX_RST      = 17'd32768;
  localparam logic [GAIN_W-1:0] STEREO_WIDTH_RST = 17'd32768;
  localparam logic [GAIN_W:0]   UNITY_GAIN       = 18'd65536;

  localparam logic signed [ACC_W-1:0] SAMPLE_MAX = ACC_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic signed [ACC_W-1:0] SAMPLE_MIN = -SAMPLE_MAX - ACC_W'(1);

  // ---------------------------------------------------------------- sine table
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef logic [SINE_MAG_W-1:0] quarter_tab_t [QUARTER];

  function automatic logic [SINE_MAG_W-1:0] quarter_sine(input int unsigned r);
    logic [63:0]        a;
    logic [63:0]        a2;
    logic [63:0]        t;
    logic signed [63:0] sum;
    logic [63:0]        val;
    a   = (64'(r) * HALF_PI_Q30) >> QUARTER_BITS;
    a2  = (a * a) >> 30;
    sum = $signed(a);
    t   = ((a * a2) >> 30) / 6;
    sum = sum - $signed(t);
    t   = ((t * a2) >> 30) / 20;
    sum = sum + $signed(t);
    t   = ((t * a2) >> 30) / 42;
    sum = sum - $signed(t);
    t   = ((t * a2) >> 30) / 72;
    sum = sum + $signed(t);
    t   = ((t * a2) >> 30) / 110;
    sum = sum - $signed(t);
    t   = ((t * a2) >> 30) / 156;
    sum = sum + $signed(t);
    if (sum < 0) begin
      sum = 0;
    end
    val = (64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (val > 64'd32767) begin
      val = 64'd32767;
    end
    return val[SINE_MAG_W-1:0];
  endfunction

  function automatic quarter_tab_t build_quarter();
    quarter_tab_t tab;
    for (int k = 0; k < QUARTER; k++) begin
      tab[k] = quarter_sine(k);
    end
    return tab;
  endfunction

  localparam quarter_tab_t           QUARTER_SINE = build_quarter();
  localparam logic [SINE_MAG_W-1:0] SINE_PEAK    = quarter_sine(QUARTER);

  // ---------------------------------------------------------------- microcode
  localparam int STEP_W = 5;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_IDLE = 5'd0;
  localparam step_t STEP_LAST = 5'd18;

  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_WAIT_IN,
    SEQ_FINISH,
    SEQ_JUMP0
  } seq_op_t;

  typedef enum logic [2:0] {
    MA_XL,
    MA_XR,
    MA_SINE,
    MA_SIDE,
    MA_WL,
    MA_WR
  } mul_a_t;

  typedef enum logic [2:0] {
    MB_LFO,
    MB_DEPTH,
    MB_WIDTH,
    MB_DRY,
    MB_WET
  } mul_b_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  typedef enum logic [2:0] {
    WB_NONE,
    WB_LFO,
    WB_ML,
    WB_MR,
    WB_MIDSIDE,
    WB_WLR,
    WB_OL,
    WB_OUT
  } wb_t;

  typedef struct packed {
    seq_op_t seq;
    logic    sine_ld;
    logic    mul_en;
    mul_a_t  mul_a;
    mul_b_t  mul_b;
    acc_op_t acc_op;
    wb_t     wb;
  } ucode_t;

  localparam ucode_t UCODE_NOP = '{
    seq: SEQ_NEXT, sine_ld: 1'b0, mul_en: 1'b0, mul_a: MA_XL, mul_b: MB_LFO,
    acc_op: ACC_HOLD, wb: WB_NONE
  };

  // Multiplier result lands in the step after mul_en; accumulator writeback reads
  // the value from before the same edge.
  function automatic ucode_t ucode_rom(input step_t s);
    ucode_t w;
    w = UCODE_NOP;
    case (s)
      5'd0:  w.seq = SEQ_WAIT_IN;
      5'd1:  w.sine_ld = 1'b1;
      5'd2:  begin w.mul_en = 1'b1; w.mul_a = MA_SINE; w.mul_b = MB_DEPTH; end
      5'd3:  w.acc_op = ACC_LOAD;
      5'd4:  w.wb = WB_LFO;
      5'd5:  begin w.mul_en = 1'b1; w.mul_a = MA_XL; w.mul_b = MB_LFO; end
      5'd6:  begin
        w.acc_op = ACC_LOAD;
        w.mul_en = 1'b1; w.mul_a = MA_XR; w.mul_b = MB_LFO;
      end
      5'd7:  begin w.wb = WB_ML; w.acc_op = ACC_LOAD; end
      5'd8:  w.wb = WB_MR;
      5'd9:  w.wb = WB_MIDSIDE;
      5'd10: begin w.mul_en = 1'b1; w.mul_a = MA_SIDE; w.mul_b = MB_WIDTH; end
      5'd11: w.acc_op = ACC_LOAD;
      5'd12: w.wb = WB_WLR;
      5'd13: begin w.mul_en = 1'b1; w.mul_a = MA_XL; w.mul_b = MB_DRY; end
      5'd14: begin
        w.acc_op = ACC_LOAD;
        w.mul_en = 1'b1; w.mul_a = MA_WL; w.mul_b = MB_WET;
      end
      5'd15: begin
        w.acc_op = ACC_ADD;
        w.mul_en = 1'b1; w.mul_a = MA_XR; w.mul_b = MB_DRY;
      end
      5'd16: begin
        w.wb = WB_OL; w.acc_op = ACC_LOAD;
        w.mul_en = 1'b1; w.mul_a = MA_WR; w.mul_b = MB_WET;
      end
      5'd17: w.acc_op = ACC_ADD;
      5'd18: begin w.wb = WB_OUT; w.seq = SEQ_FINISH; end
      default: w.seq = SEQ_JUMP0;
    endcase
    return w;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] saturate_sample(
    input logic signed [ACC_W-1:0] v
  );
    logic signed [ACC_W-1:0] c;
    c = v;
    if (v > SAMPLE_MAX) begin
      c = SAMPLE_MAX;
    end else if (v < SAMPLE_MIN) begin
      c = SAMPLE_MIN;
    end
    return c[SAMPLE_BITS-1:0];
  endfunction

endpackage

// ===== sv/srm_in_if.sv =====
interface srm_in_if;
  import srm_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;
  logic                          block_end;

  modport source (output valid, output left_in, output right_in, output block_end,
                  input ready);
  modport sink   (input valid, input left_in, input right_in, input block_end,
                  output ready);
endinterface

// ===== sv/srm_out_if.sv =====
interface srm_out_if;
  import srm_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;
  logic                          block_end_out;

  modport source (output valid, output left_out, output right_out, output block_end_out,
                  input ready);
  modport sink   (input valid, input left_out, input right_out, input block_end_out,
                  output ready);
endinterface

// ===== sv/srm_sine_rom.sv =====
module srm_sine_rom (
  input  logic                                 clk,
  input  logic                                 ld,
  input  logic [srm_pkg::SINE_INDEX_BITS-1:0]  idx,
  output logic signed [srm_pkg::SINE_W-1:0]    sine
);
  import srm_pkg::*;

  logic [1:0]              quad;
  logic [QUARTER_BITS-1:0] r;
  logic [QUARTER_BITS-1:0] r_mirror;
  logic [SINE_MAG_W-1:0]   mag;
  logic signed [SINE_W-1:0] mag_s;

  assign quad     = idx[SINE_INDEX_BITS-1 -: 2];
  assign r        = idx[QUARTER_BITS-1:0];
  assign r_mirror = QUARTER_BITS'(~r + 1'b1);

  // odd quadrants run the quarter wave backwards; their first entry is the peak
  always_comb begin
    if (!quad[0]) begin
      mag = QUARTER_SINE[r];
    end else if (r == '0) begin
      mag = SINE_PEAK;
    end else begin
      mag = QUARTER_SINE[r_mirror];
    end
  end

  assign mag_s = $signed({1'b0, mag});

  always_ff @(posedge clk) begin
    if (ld) begin
      sine <= quad[1] ? -mag_s : mag_s;
    end
  end
endmodule

// ===== sv/stereo_ring_modulator.sv =====
// Channel     Dir  Payload                                  Transaction
// frame_in    in   left_in, right_in, block_end             valid && ready
// frame_out   out  left_out, right_out, block_end_out       valid && ready
// cfg         in   cfg_index, cfg_data                      cfg_we
//
// A frame runs through the microprogram after its input transaction; its last
// step loads the output register. frame_in is ready only when idle, so a new
// frame waits until the previous result is loaded. The rate is set by the length
// of the microprogram driving the single shared 28x18 multiplier and accumulator.
// Reset (rst, synchronous) loads register defaults and clears the phase, the
// step counter and the output valid; the sine table is constant and needs no fill.
// While the output register is held by a stalled sink the sequencer waits on
// its last step and frame_in stays not ready.
module stereo_ring_modulator (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [srm_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [srm_pkg::CFG_DATA_W-1:0]     cfg_data,
  srm_in_if.sink                             frame_in,
  srm_out_if.source                          frame_out
);
  import srm_pkg::*;

  // configuration registers
  logic [31:0]       tone_step;
  logic [15:0]       phase_offset;
  logic [GAIN_W-1:0] mod_depth;
  logic [GAIN_W-1:0] wet_mix;
  logic [GAIN_W-1:0] stereo_width;

  // sequencer
  step_t  step;
  step_t  step_next;
  ucode_t uc;
  logic   in_take;
  logic   out_free;
  logic   advance;

  // datapath
  logic [31:0]                   osc_phase;
  logic [31:0]                   phase_sum;
  logic signed [SAMPLE_BITS-1:0] xl;
  logic signed [SAMPLE_BITS-1:0] xr;
  logic                          be;
  logic signed [SINE_W-1:0]      sine;
  logic signed [LFO_W-1:0]       lfo;
  logic signed [MOD_W-1:0]       ml;
  logic signed [MOD_W-1:0]       mr;
  logic signed [MOD_W-1:0]       mid;
  logic signed [MOD_W-1:0]       side;
  logic signed [WET_W-1:0]       wl;
  logic signed [WET_W-1:0]       wr;
  logic signed [SAMPLE_BITS-1:0] ol;
  logic signed [MUL_B_W-1:0]     dry;
  logic signed [MUL_A_W-1:0]     mul_a;
  logic signed [MUL_B_W-1:0]     mul_b;
  logic signed [PROD_W-1:0]      prod;
  logic signed [ACC_W-1:0]       acc;
  logic signed [ACC_W-1:0]       acc_s16;
  logic signed [ACC_W-1:0]       acc_s15;
  logic signed [WET_W-1:0]       sw;
  logic signed [MOD_W:0]         ms_sum;
  logic signed [MOD_W:0]         ms_diff;

  // ------------------------------------------------------------ configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      tone_step    <= TONE_STEP_RST;
      phase_offset <= PHASE_OFFSET_RST;
      mod_depth    <= MOD_DEPTH_RST;
      wet_mix      <= WET_MIX_RST;
      stereo_width <= STEREO_WIDTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TONE_STEP:    tone_step    <= cfg_data;
        REG_PHASE_OFFSET: phase_offset <= cfg_data[15:0];
        REG_MOD_DEPTH:    mod_depth    <= cfg_data[GAIN_W-1:0];
        REG_WET_MIX:      wet_mix      <= cfg_data[GAIN_W-1:0];
        REG_STEREO_WIDTH: stereo_width <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------ sequencer
  assign uc       = ucode_rom(step);
  assign in_take  = frame_in.valid && frame_in.ready;
  assign out_free = !frame_out.valid || frame_out.ready;
  assign frame_in.ready = (uc.seq == SEQ_WAIT_IN);

  always_comb begin
    step_next = step;
    advance   = 1'b1;
    case (uc.seq)
      SEQ_NEXT:    step_next = step + 1'b1;
      SEQ_WAIT_IN: begin
        advance = in_take;
        if (in_take) begin
          step_next = step + 1'b1;
        end
      end
      SEQ_FINISH:  begin
        advance = out_free;
        if (out_free) begin
          step_next = STEP_IDLE;
        end
      end
      SEQ_JUMP0:   step_next = STEP_IDLE;
      default:     step_next = STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

  // ------------------------------------------------------------ oscillator
  always_ff @(posedge clk) begin
    if (rst) begin
      osc_phase <= '0;
    end else if (in_take) begin
      osc_phase <= osc_phase + tone_step;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      xl <= frame_in.left_in;
      xr <= frame_in.right_in;
      be <= frame_in.block_end;
    end
  end

  assign phase_sum = osc_phase + {phase_offset, 16'd0};

  srm_sine_rom u_sine_rom (
    .clk  (clk),
    .ld   (uc.sine_ld),
    .idx  (phase_sum[31 -: SINE_INDEX_BITS]),
    .sine (sine)
  );

  // ------------------------------------------------------------ multiplier
  assign dry = $signed(UNITY_GAIN) - $signed({1'b0, wet_mix});

  always_comb begin
    case (uc.mul_a)
      MA_XL:   mul_a = MUL_A_W'(xl);
      MA_XR:   mul_a = MUL_A_W'(xr);
      MA_SINE: mul_a = MUL_A_W'(sine);
      MA_SIDE: mul_a = MUL_A_W'(side);
      MA_WL:   mul_a = wl;
      MA_WR:   mul_a = wr;
      default: mul_a = '0;
    endcase
    case (uc.mul_b)
      MB_LFO:   mul_b = lfo;
      MB_DEPTH: mul_b = $signed({1'b0, mod_depth});
      MB_WIDTH: mul_b = $signed({1'b0, stereo_width});
      MB_DRY:   mul_b = dry;
      MB_WET:   mul_b = $signed({1'b0, wet_mix});
      default:  mul_b = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (uc.mul_en) begin
      prod <= mul_a * mul_b;
    end
  end

  always_ff @(posedge clk) begin
    case (uc.acc_op)
      ACC_LOAD: acc <= ACC_W'(prod);
      ACC_ADD:  acc <= acc + ACC_W'(prod);
      default:  ;
    endcase
  end

  // ------------------------------------------------------------ writeback
  assign acc_s16 = acc >>> 16;
  assign acc_s15 = acc >>> 15;
  assign sw      = WET_W'(acc_s16);
  assign ms_sum  = (MOD_W+1)'(ml) + (MOD_W+1)'(mr);
  assign ms_diff = (MOD_W+1)'(ml) - (MOD_W+1)'(mr);

  always_ff @(posedge clk) begin
    case (uc.wb)
      WB_LFO:     lfo <= LFO_W'(acc_s16);
      WB_ML:      ml  <= MOD_W'(acc_s15);
      WB_MR:      mr  <= MOD_W'(acc_s15);
      WB_MIDSIDE: begin
        mid  <= MOD_W'(ms_sum >>> 1);
        side <= MOD_W'(ms_diff >>> 1);
      end
      WB_WLR:     begin
        wl <= WET_W'(mid) + sw;
        wr <= WET_W'(mid) - sw;
      end
      WB_OL:      ol <= saturate_sample(acc_s16);
      default:    ;
    endcase
  end

  // ------------------------------------------------------------ output register
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_out.valid <= 1'b0;
    end else if (uc.wb == WB_OUT && advance) begin
      frame_out.valid <= 1'b1;
    end else if (frame_out.ready) begin
      frame_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uc.wb == WB_OUT && advance) begin
      frame_out.left_out      <= ol;
      frame_out.right_out     <= saturate_sample(acc_s16);
      frame_out.block_end_out <= be;
    end
  end

  // ------------------------------------------------------------ assertions
  a_out_from_last_step: assert property (@(posedge clk) disable iff (rst)
    $rose(frame_out.valid) |-> $past(step) == STEP_LAST)
    else $error("output loaded outside the final microcode step");

  a_take_starts_program: assert property (@(posedge clk) disable iff (rst)
    (frame_in.valid && frame_in.ready) |=> step == STEP_IDLE + 1'b1)
    else $error("sequencer did not leave idle after an input transaction");

  a_phase_only_on_take: assert property (@(posedge clk) disable iff (rst)
    !(frame_in.valid && frame_in.ready) |=> $stable(osc_phase))
    else $error("oscillator phase moved without an input transaction");

  a_no_take_while_busy: assert property (@(posedge clk) disable iff (rst)
    (step != STEP_IDLE) |-> !frame_in.ready)
    else $error("input ready while a frame is in progress");

endmodule
